// ===== sv/sam_pkg.sv =====
// Shared constants, sequencer codes and the controller/datapath link structs
// for the suffix automaton builder. No dependencies.
package sam_pkg;

  localparam int MaxChars   = 1024;
  localparam int MaxStates  = 2 * MaxChars;
  localparam int Alphabet   = 26;
  localparam int StW        = $clog2(MaxStates);      // state index
  localparam int CntW       = StW + 1;                // state count / signed link
  localparam int SymW       = 5;                      // symbol port width
  localparam int KW         = $clog2(Alphabet + 1);   // column counter
  localparam int TAddrW     = StW + SymW;             // transition row is padded to 32

  localparam logic [KW-1:0]   KLast   = KW'(Alphabet - 1);
  localparam logic [KW-1:0]   KEnd    = KW'(Alphabet);
  localparam logic [SymW-1:0] SymMax  = SymW'(Alphabet - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MaxStates - 1);

  // sequencer codes, also used as datapath operation codes
  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLR   = 4'd2;
  localparam logic [3:0] ST_ZCUR  = 4'd3;
  localparam logic [3:0] ST_WRD   = 4'd4;
  localparam logic [3:0] ST_WCK   = 4'd5;
  localparam logic [3:0] ST_LQ    = 4'd6;
  localparam logic [3:0] ST_LQ2   = 4'd7;
  localparam logic [3:0] ST_CPY   = 4'd8;
  localparam logic [3:0] ST_RRD   = 4'd9;
  localparam logic [3:0] ST_RCK   = 4'd10;
  localparam logic [3:0] ST_LINKQ = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  typedef struct packed {
    logic [3:0]    op;
    logic [KW-1:0] k;
    logic          accept;
  } cmd_t;

  typedef struct packed {
    logic p_neg;
    logic hit_zero;
    logic hit_q;
    logic len_eq;
    logic full;
  } stat_t;

endpackage

// ===== sv/sam_ctrl.sv =====
// Sequencer for the suffix automaton builder: steps the datapath through
// clear, allocate, link walk, clone copy and redirect. Uses sam_pkg.
module sam_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            kind_i,
  input  sam_pkg::stat_t  stat_i,
  output sam_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  logic [3:0]             state_q, state_d;
  logic [sam_pkg::KW-1:0] k_q, k_d;
  logic                   accept;

  assign accept = start_i && (state_q == sam_pkg::ST_IDLE);
  assign busy_o = (state_q != sam_pkg::ST_IDLE);

  always_comb begin
    cmd_o.op     = state_q;
    cmd_o.k      = k_q;
    cmd_o.accept = accept;
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q + sam_pkg::KW'(1);
    case (state_q)
      sam_pkg::ST_INIT: begin
        if (k_q == sam_pkg::KLast) begin
          state_d = sam_pkg::ST_IDLE;
        end
      end
      sam_pkg::ST_IDLE: begin
        k_d = '0;
        if (accept) begin
          if (kind_i) begin
            state_d = sam_pkg::ST_CLR;
          end else if (stat_i.full) begin
            state_d = sam_pkg::ST_FIN;
          end else begin
            state_d = sam_pkg::ST_ZCUR;
          end
        end
      end
      sam_pkg::ST_CLR: begin
        if (k_q == sam_pkg::KLast) begin
          state_d = sam_pkg::ST_FIN;
        end
      end
      sam_pkg::ST_ZCUR: begin
        if (k_q == sam_pkg::KLast) begin
          state_d = sam_pkg::ST_WRD;
        end
      end
      sam_pkg::ST_WRD: begin
        state_d = stat_i.p_neg ? sam_pkg::ST_FIN : sam_pkg::ST_WCK;
      end
      sam_pkg::ST_WCK: begin
        state_d = stat_i.hit_zero ? sam_pkg::ST_WRD : sam_pkg::ST_LQ;
      end
      sam_pkg::ST_LQ: begin
        state_d = sam_pkg::ST_LQ2;
      end
      sam_pkg::ST_LQ2: begin
        k_d     = '0;
        state_d = stat_i.len_eq ? sam_pkg::ST_FIN : sam_pkg::ST_CPY;
      end
      sam_pkg::ST_CPY: begin
        // read column k while writing column k-1 of the clone
        if (k_q == sam_pkg::KEnd) begin
          state_d = sam_pkg::ST_RRD;
        end
      end
      sam_pkg::ST_RRD: begin
        state_d = stat_i.p_neg ? sam_pkg::ST_LINKQ : sam_pkg::ST_RCK;
      end
      sam_pkg::ST_RCK: begin
        state_d = stat_i.hit_q ? sam_pkg::ST_RRD : sam_pkg::ST_LINKQ;
      end
      sam_pkg::ST_LINKQ: begin
        state_d = sam_pkg::ST_FIN;
      end
      sam_pkg::ST_FIN: begin
        state_d = sam_pkg::ST_IDLE;
      end
      default: begin
        state_d = sam_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sam_pkg::ST_INIT;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

// ===== sv/sam_dp.sv =====
// Datapath for the suffix automaton builder: transition, length and link
// stores plus working registers and result registers. Uses sam_pkg.
module sam_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sam_pkg::cmd_t              cmd_i,
  input  logic                       kind_i,
  input  logic [sam_pkg::SymW-1:0]   symbol_i,
  input  logic                       first_of_string_i,
  output sam_pkg::stat_t             stat_o,
  output logic                       done_o,
  output logic [sam_pkg::StW-1:0]    new_state_o,
  output logic signed [sam_pkg::CntW-1:0] link_state_o,
  output logic                       clone_made_o,
  output logic [sam_pkg::StW-1:0]    clone_state_o,
  output logic [sam_pkg::CntW-1:0]   state_count_o,
  output logic                       full_res_o
);

  localparam int StW  = sam_pkg::StW;
  localparam int CntW = sam_pkg::CntW;
  localparam int SymW = sam_pkg::SymW;
  localparam int TAW  = sam_pkg::TAddrW;

  // stores
  logic [StW-1:0]  trans_mem [2**TAW];
  logic [StW-1:0]  len_mem   [sam_pkg::MaxStates];
  logic [CntW-1:0] link_mem  [sam_pkg::MaxStates];

  logic            t_we, l_we, lk_we;
  logic [TAW-1:0]  t_wa, t_ra;
  logic [StW-1:0]  t_wd, t_rd_q;
  logic [StW-1:0]  l_wa, l_ra, l_wd, l_rd_q;
  logic [StW-1:0]  lk_wa, lk_ra;
  logic [CntW-1:0] lk_wd, lk_rd_q;

  // working registers
  logic [CntW-1:0] cnt_q;
  logic [StW-1:0]  last_q, cur_q, clone_q, q_q, lenp_q;
  logic [CntW-1:0] p_q, lnk_q;
  logic [SymW-1:0] c_q;
  logic            made_q, full_q;
  logic [SymW-1:0] sym_sat;
  logic [StW-1:0]  p_idx;
  logic [SymW-1:0] kcol;

  assign sym_sat = (symbol_i > sam_pkg::SymMax) ? sam_pkg::SymMax : symbol_i;
  assign p_idx   = p_q[StW-1:0];
  assign kcol    = SymW'(cmd_i.k);

  always_comb begin
    stat_o.p_neg    = p_q[CntW-1];
    stat_o.hit_zero = (t_rd_q == '0);
    stat_o.hit_q    = (t_rd_q == q_q);
    stat_o.len_eq   = ({1'b0, l_rd_q} == ({1'b0, lenp_q} + CntW'(1)));
    stat_o.full     = (cnt_q >= sam_pkg::CntFull);
  end

  always_comb begin
    t_we  = 1'b0;
    t_wa  = {cur_q, kcol};
    t_wd  = '0;
    t_ra  = {p_idx, c_q};
    l_we  = 1'b0;
    l_wa  = cur_q;
    l_wd  = '0;
    l_ra  = p_idx;
    lk_we = 1'b0;
    lk_wa = cur_q;
    lk_wd = lnk_q;
    lk_ra = p_idx;
    case (cmd_i.op)
      sam_pkg::ST_INIT, sam_pkg::ST_CLR: begin
        t_we = 1'b1;
        t_wa = {StW'(0), kcol};
        if (cmd_i.k == '0) begin
          l_we  = 1'b1;
          l_wa  = '0;
          lk_we = 1'b1;
          lk_wa = '0;
          lk_wd = '1;
        end
      end
      sam_pkg::ST_ZCUR: begin
        t_we = 1'b1;
        if (cmd_i.k == sam_pkg::KLast) begin
          l_we = 1'b1;
          l_wd = l_rd_q + StW'(1);
        end
      end
      sam_pkg::ST_WCK: begin
        if (stat_o.hit_zero) begin
          t_we = 1'b1;
          t_wa = {p_idx, c_q};
          t_wd = cur_q;
        end
      end
      sam_pkg::ST_LQ: begin
        l_ra  = q_q;
        lk_ra = q_q;
      end
      sam_pkg::ST_LQ2: begin
        if (!stat_o.len_eq) begin
          l_we  = 1'b1;
          l_wa  = cnt_q[StW-1:0];
          l_wd  = lenp_q + StW'(1);
          lk_we = 1'b1;
          lk_wa = cnt_q[StW-1:0];
          lk_wd = lk_rd_q;
        end
      end
      sam_pkg::ST_CPY: begin
        t_ra = {q_q, kcol};
        if (cmd_i.k != '0) begin
          t_we = 1'b1;
          t_wa = {clone_q, kcol - SymW'(1)};
          t_wd = t_rd_q;
        end
      end
      sam_pkg::ST_RCK: begin
        if (stat_o.hit_q) begin
          t_we = 1'b1;
          t_wa = {p_idx, c_q};
          t_wd = clone_q;
        end
      end
      sam_pkg::ST_LINKQ: begin
        lk_we = 1'b1;
        lk_wa = q_q;
        lk_wd = {1'b0, clone_q};
      end
      sam_pkg::ST_FIN: begin
        lk_we = !full_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      trans_mem[t_wa] <= t_wd;
    end
    t_rd_q <= trans_mem[t_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      len_mem[l_wa] <= l_wd;
    end
    l_rd_q <= len_mem[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    lk_rd_q <= link_mem[lk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntW'(1);
      last_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (cmd_i.op)
        sam_pkg::ST_CLR: begin
          cnt_q  <= CntW'(1);
          last_q <= '0;
        end
        sam_pkg::ST_IDLE: begin
          if (cmd_i.accept && !kind_i && !stat_o.full) begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        sam_pkg::ST_LQ2: begin
          if (!stat_o.len_eq) begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        sam_pkg::ST_FIN: begin
          if (!full_q) begin
            last_q <= cur_q;
          end
          done_o <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sam_pkg::ST_IDLE: begin
        if (cmd_i.accept) begin
          c_q     <= sym_sat;
          made_q  <= 1'b0;
          clone_q <= '0;
          full_q  <= 1'b0;
          cur_q   <= '0;
          lnk_q   <= '0;
          if (kind_i) begin
            lnk_q <= '1;
          end else if (stat_o.full) begin
            full_q <= 1'b1;
          end else begin
            cur_q <= cnt_q[StW-1:0];
            p_q   <= first_of_string_i ? '0 : {1'b0, last_q};
          end
        end
      end
      sam_pkg::ST_WCK: begin
        if (stat_o.hit_zero) begin
          p_q <= lk_rd_q;
        end else begin
          q_q    <= t_rd_q;
          lenp_q <= l_rd_q;
        end
      end
      sam_pkg::ST_LQ2: begin
        if (stat_o.len_eq) begin
          lnk_q <= {1'b0, q_q};
        end else begin
          clone_q <= cnt_q[StW-1:0];
          made_q  <= 1'b1;
          lnk_q   <= cnt_q;
        end
      end
      sam_pkg::ST_RCK: begin
        if (stat_o.hit_q) begin
          p_q <= lk_rd_q;
        end
      end
      sam_pkg::ST_FIN: begin
        new_state_o   <= cur_q;
        link_state_o  <= lnk_q;
        clone_made_o  <= made_q;
        clone_state_o <= clone_q;
        state_count_o <= cnt_q;
        full_res_o    <= full_q;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/suffix_automaton_builder.sv =====
// Top level of the suffix automaton builder: sequencer plus datapath.
// Depends on sam_pkg, sam_ctrl and sam_dp.
//
// One item per start beat while busy is low; the result beat follows as a
// one-cycle done_o strobe that the receiver cannot stall. An append walks
// the suffix links; when a clone is made it also redirects the links. Time
// is set by the one-entry-per-cycle transition memory port: 26 columns are
// zeroed per new state and copied per clone. A refused append goes straight
// to the finish state. After reset the block is busy while the root row is
// cleared.
module suffix_automaton_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind_i,
  input  logic [sam_pkg::SymW-1:0]       symbol_i,
  input  logic                           first_of_string_i,
  output logic                           done_o,
  output logic [sam_pkg::StW-1:0]        new_state_o,
  output logic signed [sam_pkg::CntW-1:0] link_state_o,
  output logic                           clone_made_o,
  output logic [sam_pkg::StW-1:0]        clone_state_o,
  output logic [sam_pkg::CntW-1:0]       state_count_o,
  output logic                           full_res_o
);

  sam_pkg::cmd_t  cmd;
  sam_pkg::stat_t stat;

  sam_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  sam_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .symbol_i         (symbol_i),
    .first_of_string_i(first_of_string_i),
    .stat_o           (stat),
    .done_o           (done_o),
    .new_state_o      (new_state_o),
    .link_state_o     (link_state_o),
    .clone_made_o     (clone_made_o),
    .clone_state_o    (clone_state_o),
    .state_count_o    (state_count_o),
    .full_res_o       (full_res_o)
  );

endmodule

// ===== tb/sv/suffix_automaton_builder_tb.sv =====
// Self-checking testbench for suffix_automaton_builder: random start bursts,
// an in-bench automaton predictor and a per-beat field compare.
// Depends on sam_pkg and the builder RTL.
module suffix_automaton_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3_000_000;

  typedef struct packed {
    logic [sam_pkg::StW-1:0]         new_state;
    logic signed [sam_pkg::CntW-1:0] link_state;
    logic                            clone_made;
    logic [sam_pkg::StW-1:0]         clone_state;
    logic [sam_pkg::CntW-1:0]        state_count;
    logic                            full_res;
  } sam_res_t;

  logic clk_i, rst_ni, start, busy;
  logic kind_i, first_of_string_i;
  logic [sam_pkg::SymW-1:0] symbol_i;
  logic done_o, clone_made_o, full_res_o;
  logic [sam_pkg::StW-1:0] new_state_o, clone_state_o;
  logic signed [sam_pkg::CntW-1:0] link_state_o;
  logic [sam_pkg::CntW-1:0] state_count_o;

  suffix_automaton_builder u_top (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .symbol_i, .first_of_string_i,
    .done_o, .new_state_o, .link_state_o, .clone_made_o, .clone_state_o,
    .state_count_o, .full_res_o
  );

  // predicted automaton
  logic [sam_pkg::StW-1:0] trans_tbl [sam_pkg::MaxStates][sam_pkg::Alphabet];
  int             max_len [sam_pkg::MaxStates];
  int             sfx_link [sam_pkg::MaxStates];
  int             n_states, tail_state;

  sam_res_t expected_q [$];
  int errors, n_beats, n_clears, n_clones, n_refused, cycles;
  int burst_left;

  function automatic int take_state();
    int s;
    s = n_states;
    for (int k = 0; k < sam_pkg::Alphabet; k++) trans_tbl[s][k] = '0;
    max_len[s]  = 0;
    sfx_link[s] = 0;
    n_states    = s + 1;
    return s;
  endfunction

  function automatic void wipe_automaton();
    n_states    = 0;
    void'(take_state());
    sfx_link[0] = -1;
    tail_state  = 0;
  endfunction

  function automatic sam_res_t extend_automaton(logic kind,
                                                logic [sam_pkg::SymW-1:0] sym,
                                                logic first);
    sam_res_t r;
    int c, cur, cln, p, q, lnk;
    r   = '0;
    c   = (sym >= sam_pkg::Alphabet) ? sam_pkg::Alphabet - 1 : int'(sym);
    cur = 0;
    cln = 0;
    lnk = -1;
    if (kind) begin
      wipe_automaton();
    end else if (n_states + 2 > sam_pkg::MaxStates) begin
      r.full_res = 1'b1;
      lnk = 0;
    end else begin
      if (first) tail_state = 0;
      cur = take_state();
      max_len[cur] = max_len[tail_state] + 1;
      p = tail_state;
      while (p >= 0 && trans_tbl[p][c] == 0) begin
        trans_tbl[p][c] = sam_pkg::StW'(cur);
        p = sfx_link[p];
      end
      if (p < 0) begin
        sfx_link[cur] = 0;
      end else begin
        q = int'(trans_tbl[p][c]);
        if (max_len[p] + 1 == max_len[q]) begin
          sfx_link[cur] = q;
        end else begin
          cln = take_state();
          r.clone_made  = 1'b1;
          max_len[cln]  = max_len[p] + 1;
          sfx_link[cln] = sfx_link[q];
          for (int k = 0; k < sam_pkg::Alphabet; k++) trans_tbl[cln][k] = trans_tbl[q][k];
          while (p >= 0 && trans_tbl[p][c] == q) begin
            trans_tbl[p][c] = sam_pkg::StW'(cln);
            p = sfx_link[p];
          end
          sfx_link[q]   = cln;
          sfx_link[cur] = cln;
        end
      end
      tail_state = cur;
      lnk = sfx_link[cur];
    end
    r.new_state   = sam_pkg::StW'(cur);
    r.link_state  = sam_pkg::CntW'(lnk);
    r.clone_state = sam_pkg::StW'(cln);
    r.state_count = sam_pkg::CntW'(n_states);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout, %0d beats outstanding", $realtime, expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // result check first, then record the beat accepted at this edge
  always @(posedge clk_i) begin
    sam_res_t e, a;
    if (rst_ni && done_o) begin
      a = '{new_state_o, link_state_o, clone_made_o, clone_state_o,
            state_count_o, full_res_o};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result beat %h", $realtime, a);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (a.new_state !== e.new_state)
          $display("%0t new_state exp %0d got %0d", $realtime, e.new_state, a.new_state);
        if (a.link_state !== e.link_state)
          $display("%0t link_state exp %0d got %0d", $realtime, e.link_state,
                   a.link_state);
        if (a.clone_made !== e.clone_made)
          $display("%0t clone_made exp %0d got %0d", $realtime, e.clone_made,
                   a.clone_made);
        if (a.clone_state !== e.clone_state)
          $display("%0t clone_state exp %0d got %0d", $realtime, e.clone_state,
                   a.clone_state);
        if (a.state_count !== e.state_count)
          $display("%0t state_count exp %0d got %0d", $realtime, e.state_count,
                   a.state_count);
        if (a.full_res !== e.full_res)
          $display("%0t full_res exp %0d got %0d", $realtime, e.full_res, a.full_res);
        if (a !== e) errors++;
      end
    end
    if (rst_ni && start && !busy) begin
      e = extend_automaton(kind_i, symbol_i, first_of_string_i);
      n_beats++;
      if (kind_i) n_clears++;
      if (e.clone_made) n_clones++;
      if (e.full_res) n_refused++;
      expected_q.push_back(e);
    end
  end

  // one beat; start stays high into the next item unless a gap is drawn
  task automatic send_item(logic kind, logic [sam_pkg::SymW-1:0] sym, logic first);
    kind_i            <= kind;
    symbol_i          <= sym;
    first_of_string_i <= first;
    start             <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic append_word(string w, logic restart);
    for (int i = 0; i < w.len(); i++)
      send_item(1'b0, sam_pkg::SymW'(w[i] - "a"), restart && i == 0);
  endtask

  task automatic test_directed();
    append_word("abcbc", 1'b1);             // clone on the second bc
    append_word("aab", 1'b1);
    send_item(1'b0, sam_pkg::SymMax, 1'b0); // highest letter
    send_item(1'b0, 5'd26, 1'b0);           // saturates to the highest letter
    send_item(1'b0, 5'd31, 1'b1);
    send_item(1'b1, 5'd31, 1'b1);           // clear ignores the other fields
    send_item(1'b0, 5'd0, 1'b0);
    append_word("abab", 1'b0);
    send_item(1'b1, 5'd0, 1'b0);
    send_item(1'b1, 5'd17, 1'b0);
    send_item(1'b0, 5'd16, 1'b1);
  endtask

  // drive the store to capacity, then try appends that must be refused
  task automatic test_capacity();
    int guard;
    send_item(1'b1, 5'd0, 1'b0);
    guard = 0;
    while (n_states + 2 <= sam_pkg::MaxStates && guard < 2100) begin
      send_item(1'b0, sam_pkg::SymW'($urandom_range(0, 2)), $urandom_range(0, 60) == 0);
      guard++;
    end
    for (int i = 0; i < 6; i++)
      send_item(1'b0, sam_pkg::SymW'($urandom_range(0, 31)), 1'(i));
    send_item(1'b1, sam_pkg::SymW'($urandom_range(0, 31)), 1'b1);
  endtask

  task automatic test_random();
    int span;
    for (int i = 0; i < 300; i++) begin
      if (i % 50 == 0) span = $urandom_range(1, sam_pkg::Alphabet - 1);
      if ($urandom_range(0, 60) == 0)
        send_item(1'b1, sam_pkg::SymW'($urandom), 1'($urandom));
      else if ($urandom_range(0, 20) == 0)
        send_item(1'b0, sam_pkg::SymW'($urandom_range(0, 31)), 1'($urandom));
      else
        send_item(1'b0, sam_pkg::SymW'($urandom_range(0, span)),
                  $urandom_range(0, 12) == 0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = 1'b0;
    symbol_i = '0;
    first_of_string_i = 1'b0;
    errors = 0;
    n_beats = 0;
    n_clears = 0;
    n_clones = 0;
    n_refused = 0;
    cycles = 0;
    burst_left = 0;
    for (int s = 0; s < sam_pkg::MaxStates; s++) begin
      max_len[s]  = 0;
      sfx_link[s] = 0;
      for (int k = 0; k < sam_pkg::Alphabet; k++) trans_tbl[s][k] = '0;
    end
    wipe_automaton();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_capacity();
    test_random();

    start <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("ran %0d beats: %0d clears, %0d clones, %0d refused at capacity",
             n_beats, n_clears, n_clones, n_refused);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatching beats", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sam_pkg.sv
sv/sam_ctrl.sv
sv/sam_dp.sv
sv/suffix_automaton_builder.sv
tb/sv/suffix_automaton_builder_tb.sv
